@@ hdl/ctg_pkg.sv @@
// Shared constants, types and codes for the circle versus tile grid collision block.
`default_nettype none

package ctg_pkg;

  // Geometry and storage
  localparam int CELL_SIZE  = 64;
  localparam int MAX_TILES  = 4096;
  localparam int FRAC_BITS  = 8;
  localparam int CELL_SHIFT = $clog2(CELL_SIZE) + FRAC_BITS;
  localparam int ADDR_W     = $clog2(MAX_TILES);

  // Field widths
  localparam int POS_W    = 24;
  localparam int RAD_W    = 8;
  localparam int MAP_W    = 7;
  localparam int IDX_IN_W = 12;

  // Internal widths
  localparam int TIDX_W   = 2 * MAP_W;
  localparam int SUM_W    = POS_W + 2;
  localparam int TCOORD_W = SUM_W - CELL_SHIFT;
  localparam int DX_W     = RAD_W + FRAC_BITS + 1;
  localparam int SQ_W     = 2 * (RAD_W + FRAC_BITS);

  // Item queues between the parts and towards the result side
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes
  localparam logic [1:0] REG_RADIUS     = 2'd0;
  localparam logic [1:0] REG_MAP_WIDTH  = 2'd1;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd2;

  // Reset values of the registers
  localparam logic [RAD_W-1:0] RADIUS_RESET = 8'd16;
  localparam logic [MAP_W-1:0] MAP_RESET    = 7'd64;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } back_state_t;

  // Classified item as held between the front and the back
  typedef struct packed {
    logic                       is_query;
    logic                       wall;
    logic [IDX_IN_W-1:0]        tile_index;
    logic                       blocked;
    logic signed [POS_W-1:0]    pos_x;
    logic signed [POS_W-1:0]    pos_y;
    logic [MAP_W-1:0]           x0;
    logic [MAP_W-1:0]           x1;
    logic [MAP_W-1:0]           y0;
    logic [MAP_W-1:0]           y1;
  } item_t;

endpackage

`default_nettype wire

@@ hdl/ctg_ram.sv @@
// Generic single-port RAM with registered read data.
`default_nettype none

module ctg_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one word a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

@@ hdl/ctg_front.sv @@
// Front part: accepts items, forms the tile range of queries and queues them.
`default_nettype none

module ctg_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          operation,
  input  wire logic [ctg_pkg::IDX_IN_W-1:0]  tile_index,
  input  wire logic                          tile_is_wall,
  input  wire logic signed [ctg_pkg::POS_W-1:0] pos_x,
  input  wire logic signed [ctg_pkg::POS_W-1:0] pos_y,
  input  wire logic [ctg_pkg::RAD_W-1:0]     radius,
  input  wire logic [ctg_pkg::MAP_W-1:0]     map_width,
  input  wire logic [ctg_pkg::MAP_W-1:0]     map_height,
  input  wire logic                          clearing,
  output ctg_pkg::item_t                     item,
  output logic                               item_valid,
  input  wire logic                          item_pop
);

  ctg_pkg::item_t                   q [ctg_pkg::QDEPTH];
  logic [ctg_pkg::QPTR_W-1:0]       wr_ptr;
  logic [ctg_pkg::QPTR_W-1:0]       rd_ptr;
  logic [ctg_pkg::QPTR_W:0]         count;
  logic                             accept;
  ctg_pkg::item_t                   new_item;

  logic signed [ctg_pkg::SUM_W-1:0] px;
  logic signed [ctg_pkg::SUM_W-1:0] py;
  logic signed [ctg_pkg::SUM_W-1:0] roff;
  logic signed [ctg_pkg::SUM_W-1:0] xs_sh;
  logic signed [ctg_pkg::SUM_W-1:0] xe_sh;
  logic signed [ctg_pkg::SUM_W-1:0] ys_sh;
  logic signed [ctg_pkg::SUM_W-1:0] ye_sh;
  logic [ctg_pkg::TCOORD_W-1:0]     x0_t;
  logic [ctg_pkg::TCOORD_W-1:0]     x1_t;
  logic [ctg_pkg::TCOORD_W-1:0]     y0_t;
  logic [ctg_pkg::TCOORD_W-1:0]     y1_t;

  // Hold off new items while the queue is full or the map is being cleared
  assign full   = (count == (ctg_pkg::QPTR_W+1)'(ctg_pkg::QDEPTH)) | clearing;
  assign accept = push & ~full;

  // Floor the circle extent by the cell size to get the tile range
  always_comb begin
    px    = ctg_pkg::SUM_W'(pos_x);
    py    = ctg_pkg::SUM_W'(pos_y);
    roff  = ctg_pkg::SUM_W'({radius, {ctg_pkg::FRAC_BITS{1'b0}}});
    xs_sh = (px - roff) >>> ctg_pkg::CELL_SHIFT;
    xe_sh = (px + roff) >>> ctg_pkg::CELL_SHIFT;
    ys_sh = (py - roff) >>> ctg_pkg::CELL_SHIFT;
    ye_sh = (py + roff) >>> ctg_pkg::CELL_SHIFT;
    x0_t  = xs_sh[ctg_pkg::TCOORD_W-1:0];
    x1_t  = xe_sh[ctg_pkg::TCOORD_W-1:0];
    y0_t  = ys_sh[ctg_pkg::TCOORD_W-1:0];
    y1_t  = ye_sh[ctg_pkg::TCOORD_W-1:0];
  end

  // Classify the item; a negative far edge reads as huge and blocks too
  always_comb begin
    new_item            = '0;
    new_item.is_query   = (operation == ctg_pkg::OP_QUERY);
    new_item.wall       = tile_is_wall;
    new_item.tile_index = tile_index;
    new_item.pos_x      = pos_x;
    new_item.pos_y      = pos_y;
    new_item.blocked    = x0_t[ctg_pkg::TCOORD_W-1] | y0_t[ctg_pkg::TCOORD_W-1]
                        | (x1_t >= ctg_pkg::TCOORD_W'(map_width))
                        | (y1_t >= ctg_pkg::TCOORD_W'(map_height));
    new_item.x0         = x0_t[ctg_pkg::MAP_W-1:0];
    new_item.x1         = x1_t[ctg_pkg::MAP_W-1:0];
    new_item.y0         = y0_t[ctg_pkg::MAP_W-1:0];
    new_item.y1         = y1_t[ctg_pkg::MAP_W-1:0];
  end

  assign item_valid = (count != '0);
  assign item       = q[rd_ptr];

  // Store the item
  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= new_item;
    end
  end

  // Advance the queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= (wr_ptr == ctg_pkg::QPTR_W'(ctg_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (item_pop) begin
        rd_ptr <= (rd_ptr == ctg_pkg::QPTR_W'(ctg_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({accept, item_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/ctg_back.sv @@
// Back part: clears and writes the wall map, walks query tiles and queues results.
`default_nettype none

module ctg_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [ctg_pkg::RAD_W-1:0] radius,
  input  wire logic [ctg_pkg::MAP_W-1:0] map_width,
  input  wire ctg_pkg::item_t            item,
  input  wire logic                      item_valid,
  output logic                           item_pop,
  output logic                           clearing,
  input  wire logic                      pop,
  output logic                           empty,
  output logic                           can_move
);

  ctg_pkg::back_state_t state;
  ctg_pkg::back_state_t state_next;

  logic [ctg_pkg::ADDR_W-1:0]     clr_cnt;
  logic [ctg_pkg::MAP_W-1:0]      tx;
  logic [ctg_pkg::MAP_W-1:0]      ty;
  logic [ctg_pkg::MAP_W-1:0]      x0l;
  logic [ctg_pkg::MAP_W-1:0]      x1l;
  logic [ctg_pkg::MAP_W-1:0]      y1l;
  logic signed [ctg_pkg::POS_W-1:0] px;
  logic signed [ctg_pkg::POS_W-1:0] py;
  logic [ctg_pkg::SQ_W-1:0]       r2;
  logic                           hit;

  // Map port
  logic                           ram_we;
  logic [ctg_pkg::ADDR_W-1:0]     ram_addr;
  logic                           ram_wdata;
  logic                           ram_rdata;

  // Control decoded from the state
  logic                           start;
  logic                           issue;
  logic                           res_push;
  logic                           res_value;

  // Walk pipeline
  logic [ctg_pkg::TIDX_W-1:0]     idx_full;
  logic                           walk_last;
  logic                           s1_valid;
  logic [ctg_pkg::MAP_W-1:0]      s1_tx;
  logic [ctg_pkg::MAP_W-1:0]      s1_ty;
  logic                           s1_ok;
  logic                           s2_valid;
  logic                           s2_wall;
  logic signed [ctg_pkg::DX_W-1:0] s2_dx;
  logic signed [ctg_pkg::DX_W-1:0] s2_dy;
  logic signed [2*ctg_pkg::DX_W-1:0] prod_x;
  logic signed [2*ctg_pkg::DX_W-1:0] prod_y;
  logic                           s3_valid;
  logic                           s3_wall;
  logic [ctg_pkg::SQ_W-1:0]       s3_dxx;
  logic [ctg_pkg::SQ_W-1:0]       s3_dyy;
  logic                           hit_now;
  logic                           pipe_busy;

  // Result queue
  logic                           oq [ctg_pkg::QDEPTH];
  logic [ctg_pkg::QPTR_W-1:0]     owr_ptr;
  logic [ctg_pkg::QPTR_W-1:0]     ord_ptr;
  logic [ctg_pkg::QPTR_W:0]       ocount;
  logic                           out_full;
  logic                           out_pop;

  // Distance from a coordinate to the span of one tile along one axis
  function automatic logic signed [ctg_pkg::DX_W-1:0] axis_gap(
    input logic signed [ctg_pkg::POS_W-1:0] p,
    input logic [ctg_pkg::MAP_W-1:0]        t
  );
    logic signed [ctg_pkg::SUM_W-1:0] pe;
    logic signed [ctg_pkg::SUM_W-1:0] lo;
    logic signed [ctg_pkg::SUM_W-1:0] hi;
    logic signed [ctg_pkg::SUM_W-1:0] c;
    logic signed [ctg_pkg::SUM_W-1:0] d;
    pe = ctg_pkg::SUM_W'(p);
    lo = ctg_pkg::SUM_W'({t, {ctg_pkg::CELL_SHIFT{1'b0}}});
    hi = lo + ctg_pkg::SUM_W'(ctg_pkg::CELL_SIZE << ctg_pkg::FRAC_BITS);
    if (pe < lo) begin
      c = lo;
    end else if (pe > hi) begin
      c = hi;
    end else begin
      c = pe;
    end
    d = pe - c;
    return d[ctg_pkg::DX_W-1:0];
  endfunction

  ctg_ram #(
    .WIDTH (1),
    .DEPTH (ctg_pkg::MAX_TILES)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Tile index of the walk position and end of the walk
  assign idx_full  = ctg_pkg::TIDX_W'(ty) * ctg_pkg::TIDX_W'(map_width)
                   + ctg_pkg::TIDX_W'(tx);
  assign walk_last = (tx == x1l) && (ty == y1l);
  assign pipe_busy = s1_valid | s2_valid | s3_valid;
  assign clearing  = (state == ctg_pkg::ST_CLEAR);
  assign out_full  = (ocount == (ctg_pkg::QPTR_W+1)'(ctg_pkg::QDEPTH));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ctg_pkg::ST_CLEAR: begin
        if (clr_cnt == ctg_pkg::ADDR_W'(ctg_pkg::MAX_TILES - 1)) begin
          state_next = ctg_pkg::ST_IDLE;
        end
      end
      ctg_pkg::ST_IDLE: begin
        if (start) begin
          state_next = ctg_pkg::ST_WALK;
        end
      end
      ctg_pkg::ST_WALK: begin
        if (walk_last) begin
          state_next = ctg_pkg::ST_DRAIN;
        end
      end
      ctg_pkg::ST_DRAIN: begin
        if (!pipe_busy) begin
          state_next = ctg_pkg::ST_IDLE;
        end
      end
      default: state_next = ctg_pkg::ST_CLEAR;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx_full[ctg_pkg::ADDR_W-1:0];
    ram_wdata = 1'b0;
    item_pop  = 1'b0;
    start     = 1'b0;
    issue     = 1'b0;
    res_push  = 1'b0;
    res_value = 1'b0;
    unique case (state)
      ctg_pkg::ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_cnt;
      end
      ctg_pkg::ST_IDLE: begin
        if (item_valid) begin
          if (!item.is_query) begin
            item_pop  = 1'b1;
            ram_we    = (32'(item.tile_index) < ctg_pkg::MAX_TILES);
            ram_addr  = ctg_pkg::ADDR_W'(item.tile_index);
            ram_wdata = item.wall;
          end else if (!out_full) begin
            item_pop = 1'b1;
            if (item.blocked) begin
              res_push = 1'b1;
            end else begin
              start = 1'b1;
            end
          end
        end
      end
      ctg_pkg::ST_WALK: begin
        issue = 1'b1;
      end
      ctg_pkg::ST_DRAIN: begin
        if (!pipe_busy) begin
          res_push  = 1'b1;
          res_value = ~hit;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Advance the state and the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ctg_pkg::ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ctg_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Latch the query and step through its tiles, row by row
  always_ff @(posedge clk) begin
    if (start) begin
      tx  <= item.x0;
      ty  <= item.y0;
      x0l <= item.x0;
      x1l <= item.x1;
      y1l <= item.y1;
      px  <= item.pos_x;
      py  <= item.pos_y;
      r2  <= ctg_pkg::SQ_W'(ctg_pkg::SQ_W'(radius) * ctg_pkg::SQ_W'(radius))
             << (2 * ctg_pkg::FRAC_BITS);
    end else if (issue) begin
      if (tx == x1l) begin
        tx <= x0l;
        ty <= ty + 1'b1;
      end else begin
        tx <= tx + 1'b1;
      end
    end
  end

  // Square the gaps and flag a wall tile closer than the radius
  always_comb begin
    prod_x  = s2_dx * s2_dx;
    prod_y  = s2_dy * s2_dy;
    hit_now = s3_valid & s3_wall
            & (({1'b0, s3_dxx} + {1'b0, s3_dyy}) < {1'b0, r2});
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    s1_tx   <= tx;
    s1_ty   <= ty;
    s1_ok   <= (32'(idx_full) < ctg_pkg::MAX_TILES);
    s2_wall <= ram_rdata & s1_ok;
    s2_dx   <= axis_gap(px, s1_tx);
    s2_dy   <= axis_gap(py, s1_ty);
    s3_wall <= s2_wall;
    s3_dxx  <= prod_x[ctg_pkg::SQ_W-1:0];
    s3_dyy  <= prod_y[ctg_pkg::SQ_W-1:0];
  end

  // Pipeline valids and the hit flag
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      hit      <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      if (start) begin
        hit <= 1'b0;
      end else begin
        hit <= hit | hit_now;
      end
    end
  end

  // Result queue
  assign empty    = (ocount == '0);
  assign can_move = oq[ord_ptr];
  assign out_pop  = pop & ~empty;

  always_ff @(posedge clk) begin
    if (res_push) begin
      oq[owr_ptr] <= res_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr_ptr <= '0;
      ord_ptr <= '0;
      ocount  <= '0;
    end else begin
      if (res_push) begin
        owr_ptr <= (owr_ptr == ctg_pkg::QPTR_W'(ctg_pkg::QDEPTH - 1)) ? '0 : owr_ptr + 1'b1;
      end
      if (out_pop) begin
        ord_ptr <= (ord_ptr == ctg_pkg::QPTR_W'(ctg_pkg::QDEPTH - 1)) ? '0 : ord_ptr + 1'b1;
      end
      case ({res_push, out_pop})
        2'b10:   ocount <= ocount + 1'b1;
        2'b01:   ocount <= ocount - 1'b1;
        default: ocount <= ocount;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == ctg_pkg::ST_CLEAR) |-> !item_pop)
    else $error("item taken during the clearing pass");

  a_result_fits: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !out_full)
    else $error("result pushed into a full result queue");

  a_write_only_when_quiet: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == ctg_pkg::ST_CLEAR) || (state == ctg_pkg::ST_IDLE)))
    else $error("map written while a walk is in flight");

  a_pipe_from_walk: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> ($past(state) == ctg_pkg::ST_WALK))
    else $error("tile read issued outside a walk");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (state == ctg_pkg::ST_DRAIN && !pipe_busy) |=> (state == ctg_pkg::ST_IDLE))
    else $error("drain did not return to idle");
`endif

endmodule

`default_nettype wire

@@ hdl/circle_tile_grid_collision.sv @@
// Top level of the circle versus tile grid collision block: registers and parts.
//
//  channel   direction  handshake          payload
//  input     in         push / full        operation, tile_index, tile_is_wall, pos_x, pos_y
//  result    out        empty / pop        can_move
//  config    in/out     psel, penable      paddr, pwrite, pwdata, prdata, pready
//
// With the back part idle, a map write is taken from the front queue and written to
// the map, and a query outside the map passes through the front queue and the result
// queue to the ports. A query covering n tiles walks them one tile per cycle through
// the single map port and a three-stage distance pipeline; the back part works on one
// item at a time.
// After reset a clearing pass writes all 4096 map entries, one a cycle, with full
// held high; register writes are taken meanwhile.
// Two-entry queues sit between the front and back and ahead of the result ports; a
// full result queue holds queries in the front queue, which then raises full.
`default_nettype none

module circle_tile_grid_collision (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          operation,
  input  wire logic [ctg_pkg::IDX_IN_W-1:0]  tile_index,
  input  wire logic                          tile_is_wall,
  input  wire logic signed [ctg_pkg::POS_W-1:0] pos_x,
  input  wire logic signed [ctg_pkg::POS_W-1:0] pos_y,
  output logic                               empty,
  input  wire logic                          pop,
  output logic                               can_move,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [3:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [ctg_pkg::RAD_W-1:0] radius;
  logic [ctg_pkg::MAP_W-1:0] map_width;
  logic [ctg_pkg::MAP_W-1:0] map_height;
  logic                      cfg_write;
  logic [1:0]                reg_index;
  ctg_pkg::item_t            item;
  logic                      item_valid;
  logic                      item_pop;
  logic                      clearing;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign reg_index = paddr[3:2];

  // Write the registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius     <= ctg_pkg::RADIUS_RESET;
      map_width  <= ctg_pkg::MAP_RESET;
      map_height <= ctg_pkg::MAP_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        ctg_pkg::REG_RADIUS:     radius     <= pwdata[ctg_pkg::RAD_W-1:0];
        ctg_pkg::REG_MAP_WIDTH:  map_width  <= pwdata[ctg_pkg::MAP_W-1:0];
        ctg_pkg::REG_MAP_HEIGHT: map_height <= pwdata[ctg_pkg::MAP_W-1:0];
        default:                 radius     <= radius;
      endcase
    end
  end

  // Read back the registers
  always_comb begin
    unique case (reg_index)
      ctg_pkg::REG_RADIUS:     prdata = 32'(radius);
      ctg_pkg::REG_MAP_WIDTH:  prdata = 32'(map_width);
      ctg_pkg::REG_MAP_HEIGHT: prdata = 32'(map_height);
      default:                 prdata = '0;
    endcase
  end

  ctg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .operation    (operation),
    .tile_index   (tile_index),
    .tile_is_wall (tile_is_wall),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .radius       (radius),
    .map_width    (map_width),
    .map_height   (map_height),
    .clearing     (clearing),
    .item         (item),
    .item_valid   (item_valid),
    .item_pop     (item_pop)
  );

  ctg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .radius     (radius),
    .map_width  (map_width),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .clearing   (clearing),
    .pop        (pop),
    .empty      (empty),
    .can_move   (can_move)
  );

endmodule

`default_nettype wire

@@ verif/circle_tile_grid_collision_tb.sv @@
// Self-checking testbench for the circle versus tile grid collision block.
`default_nettype none

module circle_tile_grid_collision_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Width of one tile in Q16.8 coordinates, and the idle-cycle limit of the watchdog
  localparam int TILE_SPAN  = ctg_pkg::CELL_SIZE << ctg_pkg::FRAC_BITS;
  localparam int HALF_SPAN  = TILE_SPAN / 2;
  localparam int IDLE_LIMIT = 20000;

  logic                             clk          = 1'b0;
  logic                             rst          = 1'b1;
  logic                             push         = 1'b0;
  logic                             full;
  logic                             operation    = ctg_pkg::OP_WRITE;
  logic [ctg_pkg::IDX_IN_W-1:0]     tile_index   = '0;
  logic                             tile_is_wall = 1'b0;
  logic signed [ctg_pkg::POS_W-1:0] pos_x        = '0;
  logic signed [ctg_pkg::POS_W-1:0] pos_y        = '0;
  logic                             empty;
  logic                             pop          = 1'b0;
  logic                             can_move;
  logic                             psel         = 1'b0;
  logic                             penable      = 1'b0;
  logic                             pwrite       = 1'b0;
  logic [3:0]                       paddr        = '0;
  logic [31:0]                      pwdata       = '0;
  logic [31:0]                      prdata;
  logic                             pready;

  // Shadow copy of the wall map and the registers
  bit                        wall_map [ctg_pkg::MAX_TILES];
  logic [ctg_pkg::RAD_W-1:0] radius_cfg = ctg_pkg::RADIUS_RESET;
  logic [ctg_pkg::MAP_W-1:0] width_cfg  = ctg_pkg::MAP_RESET;
  logic [ctg_pkg::MAP_W-1:0] height_cfg = ctg_pkg::MAP_RESET;

  bit expected_can_move [$];
  bit next_can_move;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_request       = 0;
  int hold_left          = 0;
  int idle_cycles        = 0;
  int fail_count         = 0;
  int query_count        = 0;
  int write_count        = 0;
  int result_count       = 0;

  circle_tile_grid_collision i_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .operation    (operation),
    .tile_index   (tile_index),
    .tile_is_wall (tile_is_wall),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .empty        (empty),
    .pop          (pop),
    .can_move     (can_move),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Work out whether a circle centred at (px, py) may stand on the current map
  function automatic bit predict_can_move(input logic signed [ctg_pkg::POS_W-1:0] px,
                                          input logic signed [ctg_pkg::POS_W-1:0] py);
    longint x, y, r, r2, span, mw, mh;
    longint x0, x1, y0, y1, tx, ty, idx, dx, dy;
    x    = longint'(px);
    y    = longint'(py);
    span = longint'(TILE_SPAN);
    r    = longint'(radius_cfg) << ctg_pkg::FRAC_BITS;
    r2   = r * r;
    mw   = longint'(width_cfg);
    mh   = longint'(height_cfg);
    x0   = (x - r) >>> ctg_pkg::CELL_SHIFT;
    x1   = (x + r) >>> ctg_pkg::CELL_SHIFT;
    y0   = (y - r) >>> ctg_pkg::CELL_SHIFT;
    y1   = (y + r) >>> ctg_pkg::CELL_SHIFT;
    if (x0 < 0 || y0 < 0 || x1 >= mw || y1 >= mh) return 1'b0;
    for (ty = y0; ty <= y1; ty++) begin
      for (tx = x0; tx <= x1; tx++) begin
        idx = ty * mw + tx;
        // tiles past the end of the store read as open floor
        if (idx < longint'(ctg_pkg::MAX_TILES) && wall_map[idx]) begin
          dx = (x < tx * span) ? x - tx * span :
               (x > (tx + 1) * span) ? x - (tx + 1) * span : 0;
          dy = (y < ty * span) ? y - ty * span :
               (y > (ty + 1) * span) ? y - (ty + 1) * span : 0;
          if (dx * dx + dy * dy < r2) return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  // Offer one item, hold it until taken, then update the shadow state
  task automatic send_item(input logic op, input logic [ctg_pkg::IDX_IN_W-1:0] idx,
                           input logic wall,
                           input logic signed [ctg_pkg::POS_W-1:0] px,
                           input logic signed [ctg_pkg::POS_W-1:0] py);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    operation    <= op;
    tile_index   <= idx;
    tile_is_wall <= wall;
    pos_x        <= px;
    pos_y        <= py;
    @(posedge clk);
    while (full) @(posedge clk);
    if (op == ctg_pkg::OP_WRITE) begin
      wall_map[idx] = wall;
      write_count++;
    end else begin
      expected_can_move.push_back(predict_can_move(px, py));
      query_count++;
    end
  endtask

  task automatic query(input int px, input int py);
    send_item(ctg_pkg::OP_QUERY, ctg_pkg::IDX_IN_W'($urandom), 1'($urandom),
              ctg_pkg::POS_W'(px), ctg_pkg::POS_W'(py));
  endtask

  task automatic map_write(input int idx, input int wall);
    send_item(ctg_pkg::OP_WRITE, ctg_pkg::IDX_IN_W'(idx), 1'(wall),
              ctg_pkg::POS_W'($urandom), ctg_pkg::POS_W'($urandom));
  endtask

  // Drop push, wait for every outstanding result, then let a trailing map write land
  task automatic wait_drained();
    push <= 1'b0;
    while (expected_can_move.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Write one register through the APB port and read it back
  task automatic write_reg(input logic [1:0] reg_index, input logic [31:0] value);
    logic [31:0] stored;
    case (reg_index)
      ctg_pkg::REG_RADIUS: begin
        radius_cfg = value[ctg_pkg::RAD_W-1:0];
        stored     = 32'(radius_cfg);
      end
      ctg_pkg::REG_MAP_WIDTH: begin
        width_cfg = value[ctg_pkg::MAP_W-1:0];
        stored    = 32'(width_cfg);
      end
      default: begin
        height_cfg = value[ctg_pkg::MAP_W-1:0];
        stored     = 32'(height_cfg);
      end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== stored) begin
      fail_count++;
      $display("%0t: register %0d read back: expected %0d, actual %0d",
               $time, reg_index, stored, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int r, input int w, input int h);
    wait_drained();
    write_reg(ctg_pkg::REG_RADIUS, r);
    write_reg(ctg_pkg::REG_MAP_WIDTH, w);
    write_reg(ctg_pkg::REG_MAP_HEIGHT, h);
  endtask

  // Tile coordinate mostly inside a small window, sometimes on the far map edge
  function automatic int pick_tile(input int win, input int size);
    if ($urandom_range(99) < 15) return size - 1 + int'($urandom_range(1));
    return int'($urandom_range(win)) - 1;
  endfunction

  // Map edges, touching distance, coordinate extremes and store index extremes
  task automatic test_map_edges();
    set_config(16, 64, 64);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    query(5 * TILE_SPAN + HALF_SPAN, 5 * TILE_SPAN + HALF_SPAN);
    map_write(5 * 64 + 6, 1);
    query(6 * TILE_SPAN - 4096, 5 * TILE_SPAN + HALF_SPAN);
    query(6 * TILE_SPAN - 4095, 5 * TILE_SPAN + HALF_SPAN);
    query(4096, 4096);
    query(4095, 4096);
    query(-8388608, 8388607);
    query(8388607, -8388608);
    map_write(4095, 1);
    query(63 * TILE_SPAN + HALF_SPAN, 63 * TILE_SPAN + HALF_SPAN);
    map_write(4095, 0);
    map_write(0, 1);
    query(64 * TILE_SPAN - 4096, 64 * TILE_SPAN - 4096);
    query(64 * TILE_SPAN - 4097, 64 * TILE_SPAN - 4097);
  endtask

  // Radius and map size at their extremes, including an empty map
  task automatic test_register_extremes();
    wait_drained();
    write_reg(ctg_pkg::REG_RADIUS, 0);
    query(6 * TILE_SPAN + HALF_SPAN, 5 * TILE_SPAN + HALF_SPAN);
    wait_drained();
    write_reg(ctg_pkg::REG_RADIUS, 255);
    query(30 * TILE_SPAN + HALF_SPAN, 30 * TILE_SPAN + HALF_SPAN);
    query(8 * TILE_SPAN, 5 * TILE_SPAN + HALF_SPAN);
    wait_drained();
    write_reg(ctg_pkg::REG_MAP_WIDTH, 0);
    query(HALF_SPAN, HALF_SPAN);
    wait_drained();
    write_reg(ctg_pkg::REG_MAP_WIDTH, 127);
    write_reg(ctg_pkg::REG_MAP_HEIGHT, 0);
    query(HALF_SPAN, HALF_SPAN);
    wait_drained();
    write_reg(ctg_pkg::REG_MAP_HEIGHT, 127);
    write_reg(ctg_pkg::REG_RADIUS, 16);
    query(126 * TILE_SPAN + HALF_SPAN, 126 * TILE_SPAN + HALF_SPAN);
    query(72 * TILE_SPAN + HALF_SPAN, 2 * TILE_SPAN + HALF_SPAN);
    set_config(16, 1, 1);
    query(HALF_SPAN, HALF_SPAN);
    map_write(0, 0);
    query(HALF_SPAN, HALF_SPAN);
  endtask

  // Random writes and queries around a small window of the map
  task automatic test_random_mix(input int n, input int idle, input int stall,
                                 input int r, input int w, input int h);
    int win_w, win_h, k, tx, ty;
    set_config(r, w, h);
    sender_idle_pct    = idle;
    receiver_stall_pct = stall;
    win_w = (w < 10) ? w : 10;
    win_h = (h < 10) ? h : 10;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99) < 40) begin
        if ($urandom_range(99) < 80)
          map_write(int'($urandom_range(win_h - 1)) * w + int'($urandom_range(win_w - 1)),
                    int'($urandom_range(1)));
        else
          map_write(int'($urandom_range(ctg_pkg::MAX_TILES - 1)), int'($urandom_range(1)));
      end else if ($urandom_range(99) < 10) begin
        query(int'($urandom), int'($urandom));
      end else begin
        tx = pick_tile(win_w, w);
        ty = pick_tile(win_h, h);
        query(tx * TILE_SPAN + int'($urandom_range(TILE_SPAN - 1)),
              ty * TILE_SPAN + int'($urandom_range(TILE_SPAN - 1)));
      end
    end
    wait_drained();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
  endtask

  // Hold the result side off while queries keep coming, so the input stalls
  task automatic test_full_stall();
    int k;
    set_config(16, 64, 64);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_request       = 400;
    for (k = 0; k < 30; k++)
      query(int'($urandom_range(8 * TILE_SPAN)), int'($urandom_range(8 * TILE_SPAN)));
    wait_drained();
  endtask

  // Result side: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Compare each result taken with the oldest prediction
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      result_count++;
      if (expected_can_move.size() == 0) begin
        fail_count++;
        if (fail_count <= 40)
          $display("%0t: can_move=%0b arrived with no result expected", $time, can_move);
      end else begin
        next_can_move = expected_can_move.pop_front();
        if (can_move !== next_can_move) begin
          fail_count++;
          if (fail_count <= 40)
            $display("%0t: can_move mismatch: expected %0b, actual %0b",
                     $time, next_can_move, can_move);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_map_edges();
    test_register_extremes();
    test_random_mix(350, 0, 0, 24, 16, 16);
    test_random_mix(300, 73, 0, 40, 64, 64);
    test_random_mix(300, 0, 73, 8, 40, 25);
    test_random_mix(250, 12, 12, int'($urandom_range(63)), int'($urandom_range(64, 1)),
                    int'($urandom_range(64, 1)));
    test_random_mix(50, 0, 0, 255, 20, 12);
    test_full_stall();
    wait_drained();
    $display("Checked %0d can_move results from %0d queries and %0d map writes.",
             result_count, query_count, write_count);
    $display("Covered map edges, register extremes, four idle/stall mixes and a hold-off.");
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/ctg_pkg.sv
hdl/ctg_ram.sv
hdl/ctg_front.sv
hdl/ctg_back.sv
hdl/circle_tile_grid_collision.sv
verif/circle_tile_grid_collision_tb.sv
